// File: rtl/assert_macros.svh
// Assertion helpers; clk and rst_n are taken from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off during reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/ipvrr_pkg.sv
package ipvrr_pkg;

    localparam int POS_W      = 5;
    localparam int WAY_W      = 4;
    localparam int SET_IN_W   = 6;
    localparam int PROMOTE_W  = 64;
    localparam int INSERT_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [WAY_W-1:0] way_t;
    typedef logic [SET_IN_W-1:0] set_in_t;

    typedef enum logic [1:0] {
        REQ_TOUCH = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_INVAL = 2'd2,
        REQ_QUERY = 2'd3
    } req_type_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROMOTE = 1'b0,
        CFG_INSERT  = 1'b1
    } cfg_idx_t;

    localparam logic [PROMOTE_W-1:0] PROMOTE_RST = 64'hB100_1571_0103_0100;
    localparam logic [INSERT_W-1:0]  INSERT_RST  = 4'd14;

    // Per-item setup of the position unit
    typedef struct packed {
        way_t way;
        logic set_en;
        logic shift_en;
        logic bounded;
        pos_t lo;
        pos_t hi;
        pos_t tgt;
    } pos_ctrl_t;

    typedef struct packed {
        pos_t next_pos;
        logic victim_hit;
    } pos_res_t;

endpackage

// File: rtl/ipvrr_req_if.sv
interface ipvrr_req_if;
    import ipvrr_pkg::*;

    logic      valid;
    logic      ready;
    req_type_t req_type;
    set_in_t   set_index;
    way_t      way_index;

    modport source (output valid, output req_type, output set_index, output way_index,
                    input ready);
    modport sink   (input valid, input req_type, input set_index, input way_index,
                    output ready);
endinterface

// File: rtl/ipvrr_rsp_if.sv
interface ipvrr_rsp_if;
    import ipvrr_pkg::*;

    logic valid;
    logic ready;
    way_t victim_way;
    pos_t new_position;

    modport source (output valid, output victim_way, output new_position, input ready);
    modport sink   (input valid, input victim_way, input new_position, output ready);
endinterface

// File: rtl/ipvrr_ram.sv
module ipvrr_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/ipvrr_pos_unit.sv
module ipvrr_pos_unit #(
    parameter int NUM_WAYS = 16
) (
    input  ipvrr_pkg::pos_t      pos,
    input  ipvrr_pkg::way_t      idx,
    input  ipvrr_pkg::pos_ctrl_t ctrl,
    output ipvrr_pkg::pos_res_t  res
);
    import ipvrr_pkg::*;

    localparam pos_t PARKED  = POS_W'(NUM_WAYS + 1);
    localparam pos_t LAST_RK = POS_W'(NUM_WAYS - 1);

    logic in_range;

    assign in_range = (pos >= ctrl.lo) && (!ctrl.bounded || (pos < ctrl.hi));

    always_comb
    begin
        res.victim_hit = (pos == LAST_RK);
        if (ctrl.set_en && (idx == ctrl.way))
        begin
            res.next_pos = ctrl.tgt;
        end
        else if (ctrl.shift_en && in_range && (pos < PARKED))
        begin
            res.next_pos = pos + POS_W'(1);
        end
        else
        begin
            res.next_pos = pos;
        end
    end
endmodule

// File: rtl/ipv_recency_replacement.sv
// channel | dir | beat contents
// req     | in  | req_type, set_index, way_index
// rsp     | out | victim_way, new_position
// cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
// An item passes accept/read, load, a scan of one way per cycle through the single
// position unit, then write-back with the result beat.
// After reset a clearing pass writes each of the NUM_SETS rows of the position memory;
// req.ready stays low during it, configuration writes are taken.
// Write-back waits while a previous result beat is still unaccepted.
module ipv_recency_replacement #(
    parameter int NUM_WAYS = 16,
    parameter int NUM_SETS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    ipvrr_req_if.sink                           req,
    ipvrr_rsp_if.source                         rsp,
    input  logic                                cfg_we,
    input  logic [ipvrr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ipvrr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ipvrr_pkg::*;

    `include "assert_macros.svh"

    localparam int   SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int   ROW_W  = NUM_WAYS * POS_W;
    localparam pos_t PARKED = POS_W'(NUM_WAYS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [SET_W-1:0]        clr_cnt_reg, clr_cnt_next;
    logic [PROMOTE_W-1:0]    promote_reg;
    logic [INSERT_W-1:0]     insert_reg;

    req_type_t               req_reg;
    way_t                    way_reg;
    logic [SET_W-1:0]        set_reg;
    pos_ctrl_t               ctrl_reg, ctrl_next;
    logic                    query_reg, query_next;
    pos_t                    pos_reg, pos_next;
    way_t                    cnt_reg, cnt_next;
    way_t                    victim_reg, victim_next;
    pos_t                    row_reg [NUM_WAYS];
    pos_t                    row_next [NUM_WAYS];

    logic                    out_valid_reg, out_valid_next;
    way_t                    out_victim_reg;
    pos_t                    out_pos_reg;

    logic                    in_fire;
    logic                    out_free;
    logic [SET_IN_W-1:0]     set_red;
    logic [SET_W-1:0]        set_idx;
    logic                    ram_we;
    logic [SET_W-1:0]        ram_waddr;
    logic [ROW_W-1:0]        ram_wdata;
    logic [ROW_W-1:0]        ram_rdata;
    logic [ROW_W-1:0]        init_row;
    logic [ROW_W-1:0]        packed_row;
    logic                    way_ok;
    pos_t                    old_pos;
    logic [3:0]              slot;
    pos_t                    promo_tgt;
    pos_res_t                unit_res;

    assign in_fire  = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready        = (state_reg == ST_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.victim_way   = out_victim_reg;
    assign rsp.new_position = out_pos_reg;

    // set_index mod NUM_SETS by conditional subtraction
    always_comb
    begin
        set_red = req.set_index;
        for (int k = SET_IN_W - 1; k >= 0; k--)
        begin
            if (int'(set_red) >= (NUM_SETS << k))
            begin
                set_red = set_red - SET_IN_W'(NUM_SETS << k);
            end
        end
        set_idx = SET_W'(set_red);
    end

    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            init_row[w*POS_W +: POS_W]   = POS_W'(w);
            packed_row[w*POS_W +: POS_W] = row_reg[w];
        end
    end

    assign ram_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_WRITE) && out_free);
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_cnt_reg : set_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? init_row : packed_row;

    ipvrr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (set_idx),
        .rdata (ram_rdata)
    );

    ipvrr_pos_unit #(
        .NUM_WAYS (NUM_WAYS)
    ) u_pos_unit (
        .pos  (row_reg[0]),
        .idx  (cnt_reg),
        .ctrl (ctrl_reg),
        .res  (unit_res)
    );

    // Setup decode from the row just read
    always_comb
    begin
        way_ok  = ({1'b0, way_reg} < (WAY_W + 1)'(NUM_WAYS));
        old_pos = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (way_reg == WAY_W'(w))
            begin
                old_pos = ram_rdata[w*POS_W +: POS_W];
            end
        end
        slot      = old_pos[POS_W-1] ? 4'hF : old_pos[3:0];
        promo_tgt = {1'b0, promote_reg[slot*4 +: 4]};

        ctrl_next          = '0;
        ctrl_next.way      = way_reg;
        query_next         = 1'b0;
        pos_next           = '0;
        case (req_reg)
            REQ_TOUCH:
            begin
                ctrl_next.set_en   = way_ok;
                ctrl_next.shift_en = way_ok;
                ctrl_next.bounded  = 1'b1;
                ctrl_next.lo       = promo_tgt;
                ctrl_next.hi       = old_pos;
                ctrl_next.tgt      = promo_tgt;
                pos_next           = way_ok ? promo_tgt : '0;
            end
            REQ_FILL:
            begin
                ctrl_next.set_en   = way_ok;
                ctrl_next.shift_en = way_ok;
                ctrl_next.lo       = {1'b0, insert_reg};
                ctrl_next.tgt      = {1'b0, insert_reg};
                pos_next           = way_ok ? {1'b0, insert_reg} : '0;
            end
            REQ_INVAL:
            begin
                ctrl_next.set_en   = way_ok;
                ctrl_next.tgt      = PARKED;
                pos_next           = way_ok ? PARKED : '0;
            end
            default:
            begin
                query_next         = 1'b1;
                pos_next           = way_ok ? old_pos : '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cnt_next       = cnt_reg;
        victim_next    = victim_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_next[w] = row_reg[w];
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + SET_W'(1);
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    row_next[w] = ram_rdata[w*POS_W +: POS_W];
                end
                cnt_next    = '0;
                victim_next = '0;
                state_next  = ST_SCAN;
            end
            ST_SCAN:
            begin
                for (int w = 0; w < NUM_WAYS - 1; w++)
                begin
                    row_next[w] = row_reg[w+1];
                end
                row_next[NUM_WAYS-1] = unit_res.next_pos;
                if (query_reg && unit_res.victim_hit)
                begin
                    victim_next = cnt_reg;
                end
                cnt_next = cnt_reg + WAY_W'(1);
                if (cnt_reg == WAY_W'(NUM_WAYS - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            promote_reg   <= PROMOTE_RST;
            insert_reg    <= INSERT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_PROMOTE: promote_reg <= cfg_data;
                    CFG_INSERT:  insert_reg  <= cfg_data[INSERT_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req.req_type;
            way_reg <= req.way_index;
            set_reg <= set_idx;
        end
        if (state_reg == ST_LOAD)
        begin
            ctrl_reg  <= ctrl_next;
            query_reg <= query_next;
            pos_reg   <= pos_next;
        end
        if ((state_reg == ST_WRITE) && out_free)
        begin
            out_victim_reg <= victim_reg;
            out_pos_reg    <= pos_reg;
        end
        cnt_reg    <= cnt_next;
        victim_reg <= victim_next;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            row_reg[w] <= row_next[w];
        end
    end

    `ASSERT_PROP(a_rsp_from_write, $rose(out_valid_reg) |-> $past(state_reg == ST_WRITE),
        "result beat raised outside write-back")
    `ASSERT_NEVER(a_no_overwrite, (state_reg == ST_WRITE) && ram_we && out_valid_reg && !rsp.ready,
        "write-back while result beat still pending")
    `ASSERT_PROP(a_accept_loads, in_fire |=> (state_reg == ST_LOAD),
        "accepted beat not followed by row load")
    `ASSERT_PROP(a_victim_query_only, ((state_reg == ST_SCAN) && !query_reg) |=> (victim_reg == '0),
        "victim recorded for a non-query request")
endmodule
